>>> src/mf3_pkg.sv
// Shared types and constants for the 3x3 median filter.
package mf3_pkg;

  localparam int MF3_MAX_WIDTH  = 1024;
  localparam int MF3_MAX_HEIGHT = 1024;
  localparam int MF3_CHANNELS   = 3;

  localparam int SAMPLE_W   = 8;
  localparam int NUM_CH     = 3;
  localparam int PIX_W      = SAMPLE_W * NUM_CH;
  localparam int DIM_W      = 11;
  localparam int MIN_DIM    = 3;
  localparam int WIN_SIZE   = 9;
  localparam int WIN_CENTRE = 4;
  localparam int CFG_IDX_W  = 1;

  // Results that may be outstanding between acceptance and delivery.
  localparam int OUT_QUEUE_DEPTH = 8;
  localparam int OQ_PTR_W        = $clog2(OUT_QUEUE_DEPTH);

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

endpackage

>>> src/mf3_pix_if.sv
// Input channel of the median filter: pixel and flush items.
interface mf3_pix_if;
  import mf3_pkg::*;

  logic    valid;
  logic    ready;
  logic    op;
  sample_t red_in;
  sample_t green_in;
  sample_t blue_in;

  modport source (output valid, output op, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink (input valid, input op, input red_in, input green_in,
                input blue_in, output ready);
endinterface

>>> src/mf3_res_if.sv
// Output channel of the median filter: filtered pixels with a frame end mark.
interface mf3_res_if;
  import mf3_pkg::*;

  logic    valid;
  logic    ready;
  sample_t red_out;
  sample_t green_out;
  sample_t blue_out;
  logic    frame_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_end, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input frame_end, output ready);
endinterface

>>> src/mf3_cfg_if.sv
// Configuration write channel of the median filter.
interface mf3_cfg_if;
  import mf3_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/median_filter_3x3_unit.sv
// Streaming 3x3 median filter for three-channel pixels: top level.
//
// The block takes one item per clock and keeps that rate indefinitely as long
// as results are taken. Pixels arrive in raster order; each interior pixel is
// replaced per channel by the median of its 3x3 neighbourhood, border pixels
// pass through. A result leaves one line plus one pixel of items after its
// input, so a frame is drained by frame_width+1 flush items; the last result
// of a frame carries frame_end. The two previous lines live in one line store
// memory (one read and one write per item), the window sits in registers and
// the median runs through a compare pipeline (column sort, candidates, final
// median); a result passes the line store read, window, sort and candidate
// registers and the output queue. Up to eight results may be outstanding;
// input ready drops only when eight have been accepted and not yet taken at
// the output. Writing a dimension restarts the frame.
module median_filter_3x3_unit #(
  parameter int MAX_WIDTH  = mf3_pkg::MF3_MAX_WIDTH,
  parameter int MAX_HEIGHT = mf3_pkg::MF3_MAX_HEIGHT,
  parameter int CHANNELS   = mf3_pkg::MF3_CHANNELS
) (
  input logic       clk,
  input logic       rst,
  mf3_pix_if.sink   pixels,
  mf3_res_if.source results,
  mf3_cfg_if.sink   cfg
);
  import mf3_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int OROW_W = $clog2(MAX_HEIGHT);
  localparam int MAXD   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int XW_RAW = $clog2(MAXD + 3) + 1;
  localparam int XW     = (XW_RAW > DIM_W + 1) ? XW_RAW : DIM_W + 1;
  localparam int ITEM_W = PIX_W + 1;

  function automatic sample_t max2(sample_t a, sample_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic sample_t min2(sample_t a, sample_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic sample_t med3(sample_t a, sample_t b, sample_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Returns {high, middle, low}.
  function automatic logic [3*SAMPLE_W-1:0] sort3(sample_t a, sample_t b, sample_t c);
    sample_t lo;
    sample_t hi;
    sample_t md;
    lo = min2(min2(a, b), c);
    hi = max2(max2(a, b), c);
    md = med3(a, b, c);
    return {hi, md, lo};
  endfunction

  // Configuration registers.
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic             cfg_hit;

  assign cfg.ready = 1'b1;
  assign cfg_hit   = cfg.valid && (cfg.index == CFG_FRAME_WIDTH ||
                                   cfg.index == CFG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(1024);
      frame_height <= DIM_W'(1024);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        CFG_FRAME_WIDTH:  frame_width  <= cfg.data;
        CFG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Effective frame dimensions.
  logic [XW-1:0] fw_x;
  logic [XW-1:0] fh_x;
  logic [XW-1:0] dim_w;
  logic [XW-1:0] dim_h;

  assign fw_x  = XW'(frame_width);
  assign fh_x  = XW'(frame_height);
  assign dim_w = (fw_x < XW'(MIN_DIM)) ? XW'(MIN_DIM) :
                 (fw_x > XW'(MAX_WIDTH)) ? XW'(MAX_WIDTH) : fw_x;
  assign dim_h = (fh_x < XW'(MIN_DIM)) ? XW'(MIN_DIM) :
                 (fh_x > XW'(MAX_HEIGHT)) ? XW'(MAX_HEIGHT) : fh_x;

  // Position counters.
  logic [COL_W-1:0]  in_column;
  logic [IROW_W-1:0] in_row;
  logic [COL_W-1:0]  out_column;
  logic [OROW_W-1:0] out_row;
  logic [COL_W-1:0]  in_column_next;
  logic [IROW_W-1:0] in_row_next;
  logic [COL_W-1:0]  out_column_next;
  logic [OROW_W-1:0] out_row_next;

  logic [XW-1:0] ic_x;
  logic [XW-1:0] ir_x;
  logic [XW-1:0] oc_x;
  logic [XW-1:0] or_x;
  logic          accept;
  logic          drain;
  logic          take;
  logic          emit;
  logic          interior;
  logic          last;
  logic [PIX_W-1:0] pix;

  assign ic_x = XW'(in_column);
  assign ir_x = XW'(in_row);
  assign oc_x = XW'(out_column);
  assign or_x = XW'(out_row);

  assign accept = pixels.valid && pixels.ready;
  assign drain  = ir_x >= dim_h;
  // A flush item before the frame's pixels are complete is dropped.
  assign take   = accept && !(pixels.op == OP_FLUSH && !drain);
  assign pix    = drain ? '0 : {pixels.blue_in, pixels.green_in, pixels.red_in};

  assign emit     = (ir_x >= XW'(2)) || (ir_x == XW'(1) && ic_x >= XW'(1));
  assign interior = (or_x >= XW'(1)) && (or_x + XW'(2) <= dim_h) &&
                    (oc_x >= XW'(1)) && (oc_x + XW'(2) <= dim_w);
  assign last     = (or_x + XW'(1) >= dim_h) && (oc_x + XW'(1) >= dim_w);

  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (take) begin
      if (ic_x + XW'(1) >= dim_w) begin
        in_column_next = '0;
        in_row_next    = in_row + IROW_W'(1);
      end else begin
        in_column_next = in_column + COL_W'(1);
      end
      if (emit) begin
        if (oc_x + XW'(1) >= dim_w) begin
          out_column_next = '0;
          out_row_next    = out_row + OROW_W'(1);
        end else begin
          out_column_next = out_column + COL_W'(1);
        end
      end
      if (emit && last) begin
        in_column_next  = '0;
        in_row_next     = '0;
        out_column_next = '0;
        out_row_next    = '0;
      end
    end
    if (cfg_hit) begin
      in_column_next  = '0;
      in_row_next     = '0;
      out_column_next = '0;
      out_row_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // Line store: each entry holds {older line, newer line} for one column.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] line_rd;

  // Stage 1: line store data is back.
  logic             p1_valid;
  logic             p1_emit;
  logic             p1_interior;
  logic             p1_last;
  logic [COL_W-1:0] p1_col;
  logic [PIX_W-1:0] p1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      line_rd     <= line_mem[in_column];
      p1_emit     <= emit;
      p1_interior <= interior;
      p1_last     <= last;
      p1_col      <= in_column;
      p1_pix      <= pix;
    end
  end

  // Within a frame the same column is read again only a full line later. The
  // first item of a new frame reads column 0 just as the frame's last item
  // writes it, but entries read in a frame's first row never reach a result.
  always_ff @(posedge clk) begin
    if (p1_valid) begin
      line_mem[p1_col] <= {line_rd[PIX_W-1:0], p1_pix};
    end
  end

  // Window: index row*3 + column, newest column on the right.
  logic [PIX_W-1:0] window [WIN_SIZE];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        window[i] <= '0;
      end
    end else if (p1_valid) begin
      for (int r = 0; r < 3; r++) begin
        window[r*3]     <= window[r*3 + 1];
        window[r*3 + 1] <= window[r*3 + 2];
      end
      window[2] <= line_rd[2*PIX_W-1:PIX_W];
      window[5] <= line_rd[PIX_W-1:0];
      window[8] <= p1_pix;
    end
  end

  // Stage 2: window holds the neighbourhood of this item.
  logic p2_valid;
  logic p2_interior;
  logic p2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else begin
      p2_valid <= p1_valid && p1_emit;
    end
  end

  always_ff @(posedge clk) begin
    p2_interior <= p1_interior;
    p2_last     <= p1_last;
  end

  // Stage 3: each column sorted per channel.
  sample_t s3_lo  [NUM_CH][3];
  sample_t s3_mid [NUM_CH][3];
  sample_t s3_hi  [NUM_CH][3];
  sample_t p3_lo  [NUM_CH][3];
  sample_t p3_mid [NUM_CH][3];
  sample_t p3_hi  [NUM_CH][3];
  logic             p3_valid;
  logic             p3_interior;
  logic             p3_last;
  logic [PIX_W-1:0] p3_centre;

  always_comb begin
    logic [3*SAMPLE_W-1:0] srt;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int c = 0; c < 3; c++) begin
        srt = sort3(window[c][ch*SAMPLE_W +: SAMPLE_W],
                    window[3 + c][ch*SAMPLE_W +: SAMPLE_W],
                    window[6 + c][ch*SAMPLE_W +: SAMPLE_W]);
        s3_lo[ch][c]  = srt[SAMPLE_W-1:0];
        s3_mid[ch][c] = srt[2*SAMPLE_W-1:SAMPLE_W];
        s3_hi[ch][c]  = srt[3*SAMPLE_W-1:2*SAMPLE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else begin
      p3_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    p3_lo       <= s3_lo;
    p3_mid      <= s3_mid;
    p3_hi       <= s3_hi;
    p3_interior <= p2_interior;
    p3_last     <= p2_last;
    p3_centre   <= window[WIN_CENTRE];
  end

  // Stage 4: the median is the median of these three candidates.
  sample_t          p4_a [NUM_CH];
  sample_t          p4_b [NUM_CH];
  sample_t          p4_c [NUM_CH];
  logic             p4_valid;
  logic             p4_interior;
  logic             p4_last;
  logic [PIX_W-1:0] p4_centre;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else begin
      p4_valid <= p3_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      p4_a[ch] <= max2(max2(p3_lo[ch][0], p3_lo[ch][1]), p3_lo[ch][2]);
      p4_b[ch] <= med3(p3_mid[ch][0], p3_mid[ch][1], p3_mid[ch][2]);
      p4_c[ch] <= min2(min2(p3_hi[ch][0], p3_hi[ch][1]), p3_hi[ch][2]);
    end
    p4_interior <= p3_interior;
    p4_last     <= p3_last;
    p4_centre   <= p3_centre;
  end

  // Final selection; borders and channels beyond CHANNELS keep the centre sample.
  logic [PIX_W-1:0] res_pix;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (p4_interior && ch < CHANNELS) begin
        res_pix[ch*SAMPLE_W +: SAMPLE_W] = med3(p4_a[ch], p4_b[ch], p4_c[ch]);
      end else begin
        res_pix[ch*SAMPLE_W +: SAMPLE_W] = p4_centre[ch*SAMPLE_W +: SAMPLE_W];
      end
    end
  end

  // Output queue and credit count of results accepted but not yet taken.
  logic [ITEM_W-1:0]   oq_mem [OUT_QUEUE_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wr;
  logic [OQ_PTR_W-1:0] oq_rd;
  logic [OQ_PTR_W:0]   oq_count;
  logic [OQ_PTR_W:0]   credit;
  logic                pop;
  logic [ITEM_W-1:0]   oq_head;

  assign pop     = results.valid && results.ready;
  assign oq_head = oq_mem[oq_rd];

  always_ff @(posedge clk) begin
    if (p4_valid) begin
      oq_mem[oq_wr] <= {p4_last, res_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
      credit   <= '0;
    end else begin
      if (p4_valid) begin
        oq_wr <= oq_wr + OQ_PTR_W'(1);
      end
      if (pop) begin
        oq_rd <= oq_rd + OQ_PTR_W'(1);
      end
      oq_count <= oq_count + (OQ_PTR_W+1)'(p4_valid) - (OQ_PTR_W+1)'(pop);
      credit   <= credit + (OQ_PTR_W+1)'(take && emit) - (OQ_PTR_W+1)'(pop);
    end
  end

  assign pixels.ready      = credit != (OQ_PTR_W+1)'(OUT_QUEUE_DEPTH);
  assign results.valid     = oq_count != '0;
  assign results.red_out   = oq_head[SAMPLE_W-1:0];
  assign results.green_out = oq_head[2*SAMPLE_W-1:SAMPLE_W];
  assign results.blue_out  = oq_head[3*SAMPLE_W-1:2*SAMPLE_W];
  assign results.frame_end = oq_head[PIX_W];

endmodule

>>> src/mf3_checker.sv
// Port-level assertions for the median filter, bound to its top level.
module mf3_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input mf3_pkg::sample_t out_red,
  input mf3_pkg::sample_t out_green,
  input mf3_pkg::sample_t out_blue,
  input logic             out_frame_end
);
  import mf3_pkg::*;

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_frame_end))
    else $error("result changed while stalled");

  // Reset empties the pipeline and the output queue.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

  // An empty output only fills from an accepted item that has run the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 5))
    else $error("result appeared without a matching item");

  // Input back-pressure only occurs while results are waiting at the output.
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind median_filter_3x3_unit mf3_checker u_mf3_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pixels.valid),
  .in_ready      (pixels.ready),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .out_red       (results.red_out),
  .out_green     (results.green_out),
  .out_blue      (results.blue_out),
  .out_frame_end (results.frame_end)
);
